FILE: hw/rtl/mselb_pkg.sv
// shared types and constants for the mode select echo / line buffer block
// no dependencies; imported by the top level, front end, command queue and back end

package mselb_pkg;

  localparam int LINE_DEPTH = 64;
  localparam int IDX_W      = $clog2(LINE_DEPTH);
  localparam logic [IDX_W-1:0] LINE_CAP = IDX_W'(LINE_DEPTH - 1);

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  localparam logic [7:0] SEL_ECHO_UP = 8'd87;
  localparam logic [7:0] SEL_ECHO_LO = 8'd119;
  localparam logic [7:0] SEL_LINE_UP = 8'd83;
  localparam logic [7:0] SEL_LINE_LO = 8'd115;
  localparam logic [7:0] CR_BYTE     = 8'h0D;

  typedef enum logic [1:0] {
    OP_ECHO   = 2'd0,
    OP_STORE  = 2'd1,
    OP_REPLAY = 2'd2
  } op_t;

  // aux holds the store address or the replay count
  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [IDX_W-1:0] aux;
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_UNDECIDED = 3'b001,
    MODE_ECHO      = 3'b010,
    MODE_LINE      = 3'b100
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_LOAD  = 3'b100
  } back_st_t;

endpackage

FILE: hw/rtl/mode_select_echo_line_buffer_unit.sv
// top level of the mode select echo / line buffer block
// depends on mselb_pkg, mselb_front, mselb_cmd_fifo, mselb_back
//
// usage:
//   input queue: drive in_rx_byte and push; a word is taken at a clock edge
//   with push high and full low. the first word that is 'W'/'w' selects echo,
//   'S'/'s' selects line mode; other words are ignored until one matches.
//   result queue: while empty is low, out_tx_byte / out_last_of_run hold the
//   oldest word; raise pop to take it.
//   echo: each word passes through the command queue to the output register.
//   line: words are stored until a carriage return; the line (without the CR)
//   is then replayed, out_last_of_run marking its final word. the CR passes
//   the command queue; then each word waits in an issue state for a free
//   output slot, is read from the line store (registered) and then output.
//   other commands wait during a replay; a stored word is written as taken.
//   up to 63 words are kept per line, further words are dropped.
//   a four-entry command queue lets input continue during a replay; full
//   rises only when it fills. a stalled receiver just holds the output word.
//   reset (rst_n low, synchronous) returns the mode to undecided and empties
//   both queues; the line store itself is not cleared.

module mode_select_echo_line_buffer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_tx_byte,
  output logic       out_last_of_run
);
  import mselb_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic front_push;
  logic cmd_empty;
  logic cmd_pop;

  mselb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_rx_byte (in_rx_byte),
    .cmd_push   (front_push),
    .cmd        (front_cmd)
  );

  mselb_cmd_fifo u_cmd_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (front_push),
    .wr_cmd (front_cmd),
    .full   (full),
    .rd_en  (cmd_pop),
    .rd_cmd (back_cmd),
    .empty  (cmd_empty)
  );

  mselb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (back_cmd),
    .cmd_empty       (cmd_empty),
    .cmd_pop         (cmd_pop),
    .empty           (empty),
    .pop             (pop),
    .out_tx_byte     (out_tx_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

FILE: hw/rtl/mselb_front.sv
// front end: accepts received bytes, tracks mode and line fill, emits commands
// depends on mselb_pkg

module mselb_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic                 full,
  input  logic [7:0]           in_rx_byte,
  output logic                 cmd_push,
  output mselb_pkg::cmd_t      cmd
);
  import mselb_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic [IDX_W-1:0] wi_r, wi_nxt;
  logic             accept;

  assign accept = push && !full;

  always_comb begin
    mode_nxt = mode_r;
    wi_nxt   = wi_r;
    cmd_push = 1'b0;
    cmd      = '{op: OP_ECHO, data: in_rx_byte, aux: wi_r};
    if (accept) begin
      case (mode_r)
        MODE_ECHO: begin
          cmd_push = 1'b1;
        end
        MODE_LINE: begin
          if (in_rx_byte != CR_BYTE) begin
            // bytes past capacity are dropped
            if (wi_r < LINE_CAP) begin
              cmd.op   = OP_STORE;
              cmd_push = 1'b1;
              wi_nxt   = wi_r + IDX_W'(1);
            end
          end else begin
            // empty line emits nothing
            if (wi_r != '0) begin
              cmd.op   = OP_REPLAY;
              cmd_push = 1'b1;
            end
            wi_nxt = '0;
          end
        end
        default: begin
          if (in_rx_byte == SEL_ECHO_UP || in_rx_byte == SEL_ECHO_LO) begin
            mode_nxt = MODE_ECHO;
          end else if (in_rx_byte == SEL_LINE_UP || in_rx_byte == SEL_LINE_LO) begin
            mode_nxt = MODE_LINE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_UNDECIDED;
      wi_r   <= '0;
    end else begin
      mode_r <= mode_nxt;
      wi_r   <= wi_nxt;
    end
  end

endmodule

FILE: hw/rtl/mselb_cmd_fifo.sv
// short command queue between the front end and the back end
// depends on mselb_pkg

module mselb_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  mselb_pkg::cmd_t wr_cmd,
  output logic            full,
  input  logic            rd_en,
  output mselb_pkg::cmd_t rd_cmd,
  output logic            empty
);
  import mselb_pkg::*;

  cmd_t                 q_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [CMD_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CMD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_wr, do_rd;

  assign full   = (cnt_r == CMD_CNT_W'(CMD_DEPTH));
  assign empty  = (cnt_r == '0);
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_cmd = q_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wptr_r + CMD_PTR_W'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rptr_r + CMD_PTR_W'(1);
    end
    case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + CMD_CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CMD_CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wptr_r] <= wr_cmd;
    end
  end

endmodule

FILE: hw/rtl/mselb_back.sv
// back end: line store memory, replay sequencer and output register
// depends on mselb_pkg

module mselb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  mselb_pkg::cmd_t cmd,
  input  logic            cmd_empty,
  output logic            cmd_pop,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      out_tx_byte,
  output logic            out_last_of_run
);
  import mselb_pkg::*;

  back_st_t         st_r, st_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       mem [LINE_DEPTH];
  logic [7:0]       rd_data_r;
  logic             wr_en, rd_en;
  logic             out_valid_r, out_load;
  logic [7:0]       out_data;
  logic             out_last;
  logic             slot_free;
  logic             is_last;

  assign slot_free = !out_valid_r || pop;
  assign is_last   = ((k_r + IDX_W'(1)) == cnt_r);

  always_comb begin
    st_nxt   = st_r;
    k_nxt    = k_r;
    cnt_nxt  = cnt_r;
    cmd_pop  = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    out_data = cmd.data;
    out_last = 1'b1;
    case (st_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          case (cmd.op)
            OP_STORE: begin
              wr_en   = 1'b1;
              cmd_pop = 1'b1;
            end
            OP_REPLAY: begin
              cmd_pop = 1'b1;
              cnt_nxt = cmd.aux;
              k_nxt   = '0;
              st_nxt  = ST_ISSUE;
            end
            default: begin
              if (slot_free) begin
                out_load = 1'b1;
                cmd_pop  = 1'b1;
              end
            end
          endcase
        end
      end
      ST_ISSUE: begin
        // read only once the output slot is free, so the load never waits
        if (slot_free) begin
          rd_en  = 1'b1;
          st_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        out_load = 1'b1;
        out_data = rd_data_r;
        out_last = is_last;
        k_nxt    = k_r + IDX_W'(1);
        st_nxt   = is_last ? ST_IDLE : ST_ISSUE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    if (out_load) begin
      out_tx_byte     <= out_data;
      out_last_of_run <= out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cmd.aux] <= cmd.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[k_r];
    end
  end

  assign empty = !out_valid_r;

endmodule

FILE: hw/rtl/mselb_checker.sv
// port-level checks for the mode select echo / line buffer block
// depends on mode_select_echo_line_buffer_unit; bound to it below

module mselb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input logic [7:0] in_rx_byte,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_tx_byte,
  input logic       out_last_of_run
);

  // a waiting word stays put until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_tx_byte) && $stable(out_last_of_run)))
    else $error("output word changed or vanished while stalled");

  // reset empties both queues
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  // words taken after reset only pick the mode until one matches, so nothing can come out yet
  a_no_early_out: assert property (@(posedge clk)
    (!rst_n ##1 rst_n) |=> empty)
    else $error("result word too soon after reset");

  // an idle block with nothing pending cannot fill the input queue
  a_no_spurious_full: assert property (@(posedge clk) disable iff (!rst_n)
    (!full && !push) |=> !full)
    else $error("full rose without an accepted word");

endmodule

bind mode_select_echo_line_buffer_unit mselb_checker u_mselb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .push            (push),
  .full            (full),
  .in_rx_byte      (in_rx_byte),
  .empty           (empty),
  .pop             (pop),
  .out_tx_byte     (out_tx_byte),
  .out_last_of_run (out_last_of_run)
);
